// ----- src/cpnt_pkg.sv -----
// cpnt_pkg: constants, types and state encoding for the pedestal and noise tracker
// no dependencies
package cpnt_pkg;

    localparam int LINKS              = 24;
    localparam int BOARDS_PER_LINK    = 40;
    localparam int CHANNELS_PER_BOARD = 64;
    localparam int SAMPLE_BITS        = 10;
    localparam int FRACTION_BITS      = 12;

    localparam int DEPTH      = LINKS * BOARDS_PER_LINK * CHANNELS_PER_BOARD;
    localparam int ADDR_BITS  = $clog2(DEPTH);
    localparam int COUNT_BITS = 32;
    localparam int MEAN_BITS  = 22;
    localparam int M2_BITS    = 60;
    localparam int Q_BITS     = 22;
    localparam int DIFF_BITS  = SAMPLE_BITS + FRACTION_BITS + 1;
    localparam int ROOT_BITS  = 32;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [M2_BITS-1:0]    M2_MAX    = '1;
    localparam logic [Q_BITS-1:0]     Q_MAX     = '1;

    typedef struct packed {
        logic [4:0]             link_index;
        logic [5:0]             board_address;
        logic [5:0]             channel_number;
        logic [9:0]             sample_value;
        logic                   last_of_hit;
    } in_word_t;

    typedef struct packed {
        logic [4:0]             out_link;
        logic [5:0]             out_board;
        logic [5:0]             out_channel;
        logic [21:0]            pedestal_mean;
        logic [21:0]            noise_rms;
        logic [31:0]            sample_count;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_DIV1,
        ST_MEAN,
        ST_MUL,
        ST_ACC,
        ST_DIV2,
        ST_SQRT,
        ST_OUT
    } state_t;

    // shared unit operations
    typedef enum logic [1:0] {
        OP_DIV,
        OP_MUL,
        OP_SQRT
    } op_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } unit_ctl_t;

endpackage

// ----- src/cpnt_if.sv -----
// cpnt_if: valid/ready channel interfaces for input and result words
// depends on cpnt_pkg
interface cpnt_in_if;
    logic              valid;
    logic              ready;
    cpnt_pkg::in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cpnt_out_if;
    logic               valid;
    logic               ready;
    cpnt_pkg::out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/cpnt_unit.sv -----
// cpnt_unit: shared serial unit, one bit per cycle for divide, multiply and square root
// depends on cpnt_pkg
module cpnt_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  cpnt_pkg::unit_ctl_t ctl,
    input  logic [63:0]         opa,
    input  logic [31:0]         opb,
    output logic                busy,
    output logic [63:0]         result
);

    logic [63:0] acc_reg, acc_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] aux_reg, aux_next;
    logic [31:0] opb_reg, opb_next;
    logic [6:0]  cnt_reg, cnt_next;
    cpnt_pkg::op_t op_reg, op_next;
    logic        busy_reg, busy_next;

    logic [64:0] trial;
    logic [65:0] strial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        aux_reg <= aux_next;
        opb_reg <= opb_next;
        op_reg  <= op_next;
    end

    always_comb
    begin
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        aux_next  = aux_reg;
        opb_next  = opb_reg;
        op_next   = op_reg;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        trial     = '0;
        strial    = '0;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            op_next   = ctl.op;
            opb_next  = opb;
            case (ctl.op)
                cpnt_pkg::OP_DIV:
                begin
                    acc_next = opa;
                    rem_next = '0;
                    aux_next = '0;
                    cnt_next = 7'd64;
                end
                cpnt_pkg::OP_MUL:
                begin
                    acc_next = '0;
                    rem_next = opa;
                    aux_next = '0;
                    cnt_next = 7'd32;
                end
                cpnt_pkg::OP_SQRT:
                begin
                    acc_next = '0;
                    rem_next = '0;
                    aux_next = opa;
                    cnt_next = 7'd32;
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
        else if (busy_reg)
        begin
            case (op_reg)
                cpnt_pkg::OP_DIV:
                begin
                    // restoring divide, quotient shifts into acc
                    trial = {rem_reg, acc_reg[63]} - {33'd0, opb_reg};
                    if (!trial[64])
                    begin
                        rem_next = trial[63:0];
                        acc_next = {acc_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = {rem_reg[62:0], acc_reg[63]};
                        acc_next = {acc_reg[62:0], 1'b0};
                    end
                end
                cpnt_pkg::OP_MUL:
                begin
                    // shift-add, multiplier bits from lsb
                    if (opb_reg[0])
                        acc_next = acc_reg + rem_reg;
                    rem_next = {rem_reg[62:0], 1'b0};
                    opb_next = {1'b0, opb_reg[31:1]};
                end
                cpnt_pkg::OP_SQRT:
                begin
                    // two radicand bits per step, root in acc, remainder in rem
                    strial = {rem_reg[63:0], aux_reg[63:62]}
                           - {acc_reg[63:0], 2'b01};
                    if (!strial[65])
                    begin
                        rem_next = strial[63:0];
                        acc_next = {acc_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = {rem_reg[61:0], aux_reg[63:62]};
                        acc_next = {acc_reg[62:0], 1'b0};
                    end
                    aux_next = {aux_reg[61:0], 2'b00};
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
                busy_next = 1'b0;
        end
    end

    assign busy   = busy_reg;
    assign result = acc_reg;

endmodule

// ----- src/cpnt_store.sv -----
// cpnt_store: per-channel count, mean and deviation sum memory
// depends on cpnt_pkg
module cpnt_store
(
    input  logic                                             clk,
    input  logic                                             we,
    input  logic [cpnt_pkg::ADDR_BITS-1:0]                   waddr,
    input  logic [cpnt_pkg::COUNT_BITS+cpnt_pkg::MEAN_BITS+cpnt_pkg::M2_BITS-1:0] wdata,
    input  logic [cpnt_pkg::ADDR_BITS-1:0]                   raddr,
    output logic [cpnt_pkg::COUNT_BITS+cpnt_pkg::MEAN_BITS+cpnt_pkg::M2_BITS-1:0] rdata
);

    localparam int W = cpnt_pkg::COUNT_BITS + cpnt_pkg::MEAN_BITS + cpnt_pkg::M2_BITS;

    logic [W-1:0] mem [cpnt_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ----- src/channel_pedestal_noise_tracker_top.sv -----
// channel_pedestal_noise_tracker_top: sequencer around the channel store and the shared serial unit
// depends on cpnt_pkg, cpnt_if, cpnt_unit, cpnt_store
// a word with last_of_hit set is reported after a divide, a multiply, a second divide and a square
//   root, all in the one shared serial unit, plus any output stall
// input is taken only in the idle state, once the last word is done; out-of-range words are dropped
// after reset a clearing pass writes zero to all 61440 entries, one per cycle, input held off
module channel_pedestal_noise_tracker_top
(
    input  logic          clk,
    input  logic          rst_n,
    cpnt_in_if.sink       in_ch,
    cpnt_out_if.source    out_ch
);

    localparam int AB = cpnt_pkg::ADDR_BITS;
    localparam int CB = cpnt_pkg::COUNT_BITS;
    localparam int MB = cpnt_pkg::MEAN_BITS;
    localparam int M2B = cpnt_pkg::M2_BITS;
    localparam int FB = cpnt_pkg::FRACTION_BITS;
    localparam int DB = cpnt_pkg::DIFF_BITS;

    cpnt_pkg::state_t  state_reg, state_next;
    logic [AB-1:0]     addr_reg, addr_next;
    cpnt_pkg::in_word_t word_reg, word_next;
    logic [CB-1:0]     n_reg, n_next;
    logic [MB-1:0]     mean_reg, mean_next;
    logic [M2B-1:0]    m2_reg, m2_next;
    logic [DB-1:0]     x_reg, x_next;
    logic              neg_reg, neg_next;
    logic [DB-1:0]     a_reg, a_next;
    logic              ovalid_reg, ovalid_next;
    cpnt_pkg::out_word_t odata_reg, odata_next;

    cpnt_pkg::unit_ctl_t ctl;
    logic [63:0]       opa;
    logic [31:0]       opb;
    logic              ubusy;
    logic [63:0]       ures;

    logic              we;
    logic [AB-1:0]     waddr;
    logic [CB+MB+M2B-1:0] wdata, rdata;
    logic [AB-1:0]     raddr;

    logic              in_range;
    logic [AB-1:0]     in_addr;
    logic [DB-1:0]     pnew;
    logic [DB-1:0]     bdiff;
    logic [M2B:0]      m2sum;

    cpnt_unit u_unit
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .opa    (opa),
        .opb    (opb),
        .busy   (ubusy),
        .result (ures)
    );

    cpnt_store u_store
    (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign in_range = (32'(in_ch.data.link_index) < 32'(cpnt_pkg::LINKS))
                   && (32'(in_ch.data.board_address) < 32'(cpnt_pkg::BOARDS_PER_LINK))
                   && (32'(in_ch.data.channel_number) < 32'(cpnt_pkg::CHANNELS_PER_BOARD));
    assign in_addr = AB'((32'(in_ch.data.link_index) * cpnt_pkg::BOARDS_PER_LINK
                        + 32'(in_ch.data.board_address)) * cpnt_pkg::CHANNELS_PER_BOARD
                        + 32'(in_ch.data.channel_number));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= cpnt_pkg::ST_CLEAR;
            addr_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        n_reg     <= n_next;
        mean_reg  <= mean_next;
        m2_reg    <= m2_next;
        x_reg     <= x_next;
        neg_reg   <= neg_next;
        a_reg     <= a_next;
        odata_reg <= odata_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        word_next   = word_reg;
        n_next      = n_reg;
        mean_next   = mean_reg;
        m2_next     = m2_reg;
        x_next      = x_reg;
        neg_next    = neg_reg;
        a_next      = a_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        ctl.start   = 1'b0;
        ctl.op      = cpnt_pkg::OP_DIV;
        opa         = '0;
        opb         = '0;
        we          = 1'b0;
        waddr       = addr_reg;
        wdata       = '0;
        raddr       = addr_reg;
        in_ch.ready = 1'b0;
        pnew        = neg_reg ? DB'(mean_reg) - DB'(ures) : DB'(mean_reg) + DB'(ures);
        bdiff       = neg_reg ? DB'(mean_reg) - x_reg : x_reg - DB'(mean_reg);
        m2sum       = {1'b0, m2_reg} + (M2B + 1)'(ures);

        if (out_ch.ready)
            ovalid_next = 1'b0;

        case (state_reg)
            cpnt_pkg::ST_CLEAR:
            begin
                we = 1'b1;
                if (32'(addr_reg) == cpnt_pkg::DEPTH - 1)
                    state_next = cpnt_pkg::ST_IDLE;
                else
                    addr_next = addr_reg + AB'(1);
            end
            cpnt_pkg::ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                raddr       = in_addr;
                if (in_ch.valid && in_range)
                begin
                    word_next  = in_ch.data;
                    addr_next  = in_addr;
                    state_next = cpnt_pkg::ST_LOAD;
                end
            end
            cpnt_pkg::ST_LOAD:
            begin
                // read data of the addressed entry is now registered
                n_next    = (rdata[CB+MB+M2B-1 -: CB] == cpnt_pkg::COUNT_MAX)
                          ? cpnt_pkg::COUNT_MAX : rdata[CB+MB+M2B-1 -: CB] + CB'(1);
                mean_next = rdata[MB+M2B-1 -: MB];
                m2_next   = rdata[M2B-1:0];
                x_next    = DB'(word_reg.sample_value[cpnt_pkg::SAMPLE_BITS-1:0]) << FB;
                state_next = cpnt_pkg::ST_READ;
            end
            cpnt_pkg::ST_READ:
            begin
                neg_next  = x_reg < DB'(mean_reg);
                a_next    = (x_reg < DB'(mean_reg)) ? DB'(mean_reg) - x_reg
                                                   : x_reg - DB'(mean_reg);
                ctl.start = 1'b1;
                ctl.op    = cpnt_pkg::OP_DIV;
                opa       = 64'((x_reg < DB'(mean_reg)) ? DB'(mean_reg) - x_reg
                                                       : x_reg - DB'(mean_reg));
                opb       = n_reg;
                state_next = cpnt_pkg::ST_DIV1;
            end
            cpnt_pkg::ST_DIV1:
            begin
                if (!ubusy)
                    state_next = cpnt_pkg::ST_MEAN;
            end
            cpnt_pkg::ST_MEAN:
            begin
                mean_next = MB'(pnew);
                state_next = cpnt_pkg::ST_MUL;
            end
            cpnt_pkg::ST_MUL:
            begin
                // mean_reg now holds the new mean
                ctl.start = 1'b1;
                ctl.op    = cpnt_pkg::OP_MUL;
                opa       = 64'(a_reg);
                opb       = 32'(bdiff);
                state_next = cpnt_pkg::ST_ACC;
            end
            cpnt_pkg::ST_ACC:
            begin
                if (!ubusy && !ctl.start)
                begin
                    m2_next = m2sum[M2B] ? cpnt_pkg::M2_MAX : m2sum[M2B-1:0];
                    we      = 1'b1;
                    wdata   = {n_reg, mean_reg,
                               m2sum[M2B] ? cpnt_pkg::M2_MAX : m2sum[M2B-1:0]};
                    if (word_reg.last_of_hit)
                        state_next = cpnt_pkg::ST_DIV2;
                    else
                        state_next = cpnt_pkg::ST_IDLE;
                end
            end
            cpnt_pkg::ST_DIV2:
            begin
                ctl.start  = 1'b1;
                ctl.op     = cpnt_pkg::OP_DIV;
                opa        = 64'(m2_reg);
                opb        = n_reg;
                state_next = cpnt_pkg::ST_SQRT;
            end
            cpnt_pkg::ST_SQRT:
            begin
                if (!ubusy)
                begin
                    ctl.start  = 1'b1;
                    ctl.op     = cpnt_pkg::OP_SQRT;
                    opa        = ures;
                    state_next = cpnt_pkg::ST_OUT;
                end
            end
            cpnt_pkg::ST_OUT:
            begin
                if (!ubusy && (!ovalid_reg || out_ch.ready))
                begin
                    ovalid_next = 1'b1;
                    odata_next.out_link      = word_reg.link_index;
                    odata_next.out_board     = word_reg.board_address;
                    odata_next.out_channel   = word_reg.channel_number;
                    odata_next.pedestal_mean = mean_reg;
                    odata_next.noise_rms     = (ures > 64'(cpnt_pkg::Q_MAX))
                                             ? cpnt_pkg::Q_MAX : ures[cpnt_pkg::Q_BITS-1:0];
                    odata_next.sample_count  = n_reg;
                    state_next = cpnt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cpnt_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = odata_reg;

endmodule

// ----- verif/tb_channel_pedestal_noise_tracker_top.sv -----
// testbench for channel_pedestal_noise_tracker_top: random and directed sample words,
// per-channel welford predictor in a small scoreboard class, watchdog on stalls
// depends on cpnt_pkg, cpnt_if and the rtl of the tracker
module tb_channel_pedestal_noise_tracker_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 200000;
    localparam int TAIL_CYCLES = 500;

    class pedestal_scoreboard;
        bit [31:0] counts [int];
        bit [21:0] means [int];
        bit [59:0] dev_sums [int];
        cpnt_pkg::out_word_t pending_reports [$];
        int errors;

        function automatic bit [63:0] int_sqrt(bit [63:0] v);
            bit [63:0] root;
            bit [63:0] b;
            root = 0;
            b = 64'd1 << 62;
            while (b > v)
                b >>= 2;
            while (b != 0)
            begin
                if (v >= root + b)
                begin
                    v -= root + b;
                    root = (root >> 1) + b;
                end
                else
                    root >>= 1;
                b >>= 2;
            end
            return root;
        endfunction

        function void note_sample(cpnt_pkg::in_word_t w);
            int idx;
            bit [63:0] n, x, p0, p, a, b, term, m2;
            cpnt_pkg::out_word_t r;
            if (w.link_index >= cpnt_pkg::LINKS || w.board_address >= cpnt_pkg::BOARDS_PER_LINK ||
                w.channel_number >= cpnt_pkg::CHANNELS_PER_BOARD)
                return;
            idx = (int'(w.link_index) * cpnt_pkg::BOARDS_PER_LINK + int'(w.board_address))
                  * cpnt_pkg::CHANNELS_PER_BOARD + int'(w.channel_number);
            if (!counts.exists(idx))
            begin
                counts[idx] = 0;
                means[idx] = 0;
                dev_sums[idx] = 0;
            end
            if (counts[idx] != cpnt_pkg::COUNT_MAX)
                counts[idx] = counts[idx] + 1;
            n = counts[idx];
            x = 64'(w.sample_value) << cpnt_pkg::FRACTION_BITS;
            p0 = means[idx];
            if (x >= p0)
            begin
                a = x - p0;
                p = p0 + a / n;
                b = x - p;
            end
            else
            begin
                a = p0 - x;
                p = p0 - a / n;
                b = p - x;
            end
            means[idx] = p[21:0];
            term = a * b;
            m2 = dev_sums[idx];
            if (term > 64'(cpnt_pkg::M2_MAX) - m2)
                m2 = 64'(cpnt_pkg::M2_MAX);
            else
                m2 += term;
            dev_sums[idx] = m2[59:0];
            if (!w.last_of_hit)
                return;
            r.out_link = w.link_index;
            r.out_board = w.board_address;
            r.out_channel = w.channel_number;
            r.pedestal_mean = (p > 64'(cpnt_pkg::Q_MAX)) ? cpnt_pkg::Q_MAX : p[21:0];
            term = int_sqrt(m2 / n);
            r.noise_rms = (term > 64'(cpnt_pkg::Q_MAX)) ? cpnt_pkg::Q_MAX : term[21:0];
            r.sample_count = n[31:0];
            pending_reports = {pending_reports, r};
        endfunction

        function void check_report(cpnt_pkg::out_word_t got);
            cpnt_pkg::out_word_t e;
            if (pending_reports.size() == 0)
            begin
                $display("%0t unexpected report: %p", $time, got);
                errors++;
                return;
            end
            e = pending_reports.pop_front();
            if (got.out_link !== e.out_link)
                $display("%0t out_link exp %0d got %0d", $time, e.out_link, got.out_link);
            if (got.out_board !== e.out_board)
                $display("%0t out_board exp %0d got %0d", $time, e.out_board, got.out_board);
            if (got.out_channel !== e.out_channel)
                $display("%0t out_channel exp %0d got %0d", $time, e.out_channel,
                         got.out_channel);
            if (got.pedestal_mean !== e.pedestal_mean)
                $display("%0t pedestal_mean exp %0d got %0d", $time, e.pedestal_mean,
                         got.pedestal_mean);
            if (got.noise_rms !== e.noise_rms)
                $display("%0t noise_rms exp %0d got %0d", $time, e.noise_rms, got.noise_rms);
            if (got.sample_count !== e.sample_count)
                $display("%0t sample_count exp %0d got %0d", $time, e.sample_count,
                         got.sample_count);
            if (got !== e)
                errors++;
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    cpnt_in_if in_ch();
    cpnt_out_if out_ch();
    pedestal_scoreboard sb = new();
    bit calm = 0;
    int stall_cycles = 0;
    int in_idle = 0;
    int out_idle = 0;

    channel_pedestal_noise_tracker_top uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch),
                                            .out_ch(out_ch));

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    initial
    begin
        in_ch.valid = 0;
        in_ch.data = '0;
        out_ch.ready = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
                sb.check_report(out_ch.data);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles > STALL_LIMIT)
            begin
                $display("[channel_pedestal_noise_tracker_top] ERROR");
                $finish;
            end
            if (out_idle > 0)
            begin
                out_idle <= out_idle - 1;
                out_ch.ready <= 0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                out_idle <= $urandom_range(0, 7);
                out_ch.ready <= 0;
            end
            else
                out_ch.ready <= 1;
        end
    end

    task automatic send_sample(cpnt_pkg::in_word_t w);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_ch.valid <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_ch.valid <= 1;
        in_ch.data <= w;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_sample(w);
    endtask

    task automatic send_fields(int l, int b, int c, int s, bit last);
        cpnt_pkg::in_word_t w;
        w.link_index = 5'(l);
        w.board_address = 6'(b);
        w.channel_number = 6'(c);
        w.sample_value = 10'(s);
        w.last_of_hit = last;
        send_sample(w);
    endtask

    task automatic drain_reports();
        in_ch.valid <= 0;
        while (sb.pending_reports.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        cpnt_pkg::in_word_t w;
        int l, b, c;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        // directed: extremes, drops, no-report, mean moving down
        send_fields(0, 0, 0, 0, 1);
        send_fields(0, 0, 0, 1023, 1);
        send_fields(0, 0, 0, 1023, 1);
        send_fields(0, 0, 0, 0, 0);
        send_fields(0, 0, 0, 512, 1);
        send_fields(23, 39, 63, 1023, 1);
        send_fields(23, 39, 63, 0, 1);
        send_fields(24, 0, 0, 100, 1);
        send_fields(31, 63, 63, 1023, 1);
        send_fields(0, 40, 5, 7, 1);
        send_fields(5, 63, 0, 7, 1);
        send_fields(10, 20, 30, 341, 0);
        send_fields(10, 20, 30, 682, 1);
        send_fields(21, 42 - 21, 42, 1023, 1);
        send_fields(23, 39, 63, 1023, 1);
        send_fields(0, 0, 0, 0, 1);
        drain_reports();
        // random: mostly a few hot channels so counts grow
        for (int i = 0; i < 1200; i++)
        begin
            if (i == 600)
                drain_reports();
            if (i == 1050)
                calm = 1;
            case ($urandom_range(0, 9))
                0:
                begin
                    w = 28'($urandom);
                end
                1, 2:
                begin
                    w = 28'($urandom);
                    w.link_index = 5'($urandom_range(0, 23));
                    w.board_address = 6'($urandom_range(0, 39));
                end
                default:
                begin
                    l = $urandom_range(0, 1) ? 23 : $urandom_range(0, 2);
                    b = $urandom_range(0, 1) ? 39 : $urandom_range(0, 1);
                    c = $urandom_range(0, 1) ? 63 : $urandom_range(0, 1);
                    w.link_index = 5'(l);
                    w.board_address = 6'(b);
                    w.channel_number = 6'(c);
                    w.sample_value = 10'($urandom_range(0, 1) ? $urandom_range(0, 1023)
                                         : $urandom_range(480, 540));
                    w.last_of_hit = $urandom_range(0, 2) != 0;
                end
            endcase
            send_sample(w);
        end
        drain_reports();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending_reports.size() == 0)
            $display("[channel_pedestal_noise_tracker_top] OK");
        else
            $display("[channel_pedestal_noise_tracker_top] ERROR");
        $finish;
    end
endmodule

// ----- channel_pedestal_noise_tracker_top.f -----
src/cpnt_pkg.sv
src/cpnt_if.sv
src/cpnt_unit.sv
src/cpnt_store.sv
src/channel_pedestal_noise_tracker_top.sv
verif/tb_channel_pedestal_noise_tracker_top.sv
